// File: rtl/dtl_pkg.sv
// Shared types and constants of the diffusion timestep limit block.
// No dependencies; every rtl file imports this package.
package dtl_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int AXES         = 3;
    localparam int AXIS_SLOTS   = 3;
    localparam int AXIS_IDX_W   = $clog2(AXIS_SLOTS);
    localparam int WORD_W       = 32;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [WORD_W-1:0]     ONE_FIXED = WORD_W'(1) << FRAC_BITS;
    localparam logic [AXIS_SLOTS-1:0] AXES_MASK = AXIS_SLOTS'((1 << AXES) - 1);

    // register indexes on the configuration port
    localparam logic [2:0] REG_STEP_DT     = 3'd0;
    localparam logic [2:0] REG_SPACING_X   = 3'd1;
    localparam logic [2:0] REG_SPACING_Y   = 3'd2;
    localparam logic [2:0] REG_SPACING_Z   = 3'd3;
    localparam logic [2:0] REG_AXIS_ENABLE = 3'd4;

    // one classified grid point as it waits in the queue
    typedef struct packed {
        logic [AXIS_SLOTS-1:0]             mask;
        logic [AXIS_SLOTS-1:0][WORD_W-1:0] coef;
        logic                              last;
    } dtl_item_t;

    // configuration seen by the back end
    typedef struct packed {
        logic [WORD_W-1:0]                 step_dt;
        logic [AXIS_SLOTS-1:0][WORD_W-1:0] spacing;
    } dtl_cfg_t;

endpackage

// File: rtl/dtl_front.sv
// Front end: accepts grid points and marks the axes that need a limit.
// Depends on dtl_pkg.
module dtl_front (
    input  logic [dtl_pkg::AXIS_SLOTS-1:0] axis_enable,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [95:0]                    s_tdata,   // coef_x, coef_y, coef_z
    input  logic                           s_tuser,   // in_domain
    input  logic                           s_tlast,   // last
    input  logic                           q_full,
    output logic                           q_push,
    output dtl_pkg::dtl_item_t             q_item
);
    import dtl_pkg::*;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_item.last = s_tlast;
        for (int a = 0; a < AXIS_SLOTS; a++) begin
            q_item.coef[a] = s_tdata[a*WORD_W +: WORD_W];
            // skip axes outside the domain, disabled, or with zero coefficient
            q_item.mask[a] = s_tuser && axis_enable[a] && AXES_MASK[a]
                             && (s_tdata[a*WORD_W +: WORD_W] != '0);
        end
    end

endmodule

// File: rtl/dtl_queue.sv
// Short queue of classified points between front and back ends.
// Depends on dtl_pkg.
module dtl_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  dtl_pkg::dtl_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               valid,
    output dtl_pkg::dtl_item_t pop_item
);
    import dtl_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    dtl_item_t        entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_item = entries_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: rtl/dtl_div.sv
// Radix-2 restoring divider: 64-bit dividend over 33-bit divisor, quotient
// saturated to 32 bits. Depends on dtl_pkg.
module dtl_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [2*dtl_pkg::WORD_W-1:0] num,
    input  logic [dtl_pkg::WORD_W:0]   den,
    output logic                       done,
    output logic [dtl_pkg::WORD_W-1:0] quo
);
    import dtl_pkg::*;

    localparam int CNT_W = $clog2(WORD_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [WORD_W:0]   rem_reg;
    logic [WORD_W-1:0] work_reg;
    logic [WORD_W+1:0] trial;
    logic              fits;
    logic              sat;

    // quotient overflows 32 bits exactly when the upper half reaches the divisor
    assign sat   = ({1'b0, num[2*WORD_W-1:WORD_W]} >= den);
    assign trial = {rem_reg, work_reg[WORD_W-1]};
    assign fits  = (trial >= {1'b0, den});
    assign done  = done_reg;
    assign quo   = work_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= !sat;
                done_reg <= sat;
                cnt_reg  <= '0;
                rem_reg  <= {1'b0, num[2*WORD_W-1:WORD_W]};
                work_reg <= sat ? '1 : num[WORD_W-1:0];
            end else if (busy_reg) begin
                // shift in the next dividend bit, subtract where it fits
                rem_reg  <= fits ? (WORD_W+1)'(trial - {1'b0, den}) : trial[WORD_W:0];
                work_reg <= {work_reg[WORD_W-2:0], fits};
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(WORD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// File: rtl/dtl_back.sv
// Back end: walks the marked axes of each point through the shared divider,
// keeps the running minimum and drives the result register. Depends on dtl_pkg.
module dtl_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  dtl_pkg::dtl_cfg_t          cfg,
    input  logic                       q_valid,
    input  dtl_pkg::dtl_item_t         q_item,
    output logic                       q_pop,
    output logic                       div_start,
    output logic [2*dtl_pkg::WORD_W-1:0] div_num,
    output logic [dtl_pkg::WORD_W:0]   div_den,
    input  logic                       div_done,
    input  logic [dtl_pkg::WORD_W-1:0] div_quo,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [dtl_pkg::WORD_W-1:0] m_tdata    // min_step
);
    import dtl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NEXT,
        S_START,
        S_WAIT,
        S_FIN
    } state_t;

    state_t                            state_reg;
    logic [AXIS_SLOTS-1:0]             mask_reg;
    logic [AXIS_SLOTS-1:0][WORD_W-1:0] coef_reg;
    logic                              last_reg;
    logic [WORD_W-1:0]                 cur_reg;
    logic                              batch_start_reg;
    logic [2*WORD_W-1:0]               sq_reg;
    logic [WORD_W:0]                   den_reg;
    logic                              m_tvalid_reg;
    logic [WORD_W-1:0]                 m_tdata_reg;
    logic [AXIS_IDX_W-1:0]             sel_idx;
    logic                              emit;

    // lowest axis still pending
    always_comb begin
        sel_idx = '0;
        for (int a = AXIS_SLOTS - 1; a >= 0; a--) begin
            if (mask_reg[a]) begin
                sel_idx = AXIS_IDX_W'(a);
            end
        end
    end

    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign div_start = (state_reg == S_START);
    assign div_num   = sq_reg;
    assign div_den   = den_reg;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign emit      = (state_reg == S_FIN) && last_reg && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            batch_start_reg <= 1'b1;
            cur_reg         <= '1;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        mask_reg  <= q_item.mask;
                        coef_reg  <= q_item.coef;
                        last_reg  <= q_item.last;
                        cur_reg   <= batch_start_reg ? cfg.step_dt : cur_reg;
                        state_reg <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (mask_reg == '0) begin
                        state_reg <= S_FIN;
                    end else begin
                        sq_reg <= (2*WORD_W)'(cfg.spacing[sel_idx])
                                  * (2*WORD_W)'(cfg.spacing[sel_idx]);
                        den_reg <= {coef_reg[sel_idx], 1'b0};
                        mask_reg[sel_idx] <= 1'b0;
                        state_reg <= S_START;
                    end
                end
                S_START: begin
                    state_reg <= S_WAIT;
                end
                S_WAIT: begin
                    if (div_done) begin
                        if (div_quo < cur_reg) begin
                            cur_reg <= div_quo;
                        end
                        state_reg <= S_NEXT;
                    end
                end
                S_FIN: begin
                    if (!last_reg) begin
                        batch_start_reg <= 1'b0;
                        state_reg       <= S_IDLE;
                    end else if (emit) begin
                        // emit and reload for the next list
                        m_tdata_reg     <= cur_reg;
                        cur_reg         <= '1;
                        batch_start_reg <= 1'b1;
                        state_reg       <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/diffusion_timestep_limit.sv
// Top level: configuration registers, front end, queue, back end, divider.
// Depends on dtl_pkg, dtl_front, dtl_queue, dtl_div, dtl_back.
// Each point occupies the back end while its axes to check (0..3) pass one at
// a time through the shared 32-step radix-2 divider; no new point is taken
// from the queue before the back end is done with the last. An axis whose
// quotient saturates skips the divider steps. min_step is registered.
// Synchronous reset (aresetn low) sets the configuration and control registers
// to their defaults and empties the queue; the next point starts a new list.
module diffusion_timestep_limit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // coef_x [31:0], coef_y [63:32], coef_z [95:64]
    input  logic        s_tuser,   // in_domain
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // min_step
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dtl_pkg::*;

    logic [WORD_W-1:0]     step_dt_reg;
    logic [WORD_W-1:0]     spacing_x_reg;
    logic [WORD_W-1:0]     spacing_y_reg;
    logic [WORD_W-1:0]     spacing_z_reg;
    logic [AXIS_SLOTS-1:0] axis_enable_reg;
    logic [2:0]            reg_idx;
    logic                  cfg_write;
    dtl_cfg_t              cfg;

    logic                  q_push;
    logic                  q_pop;
    logic                  q_full;
    logic                  q_valid;
    dtl_item_t             q_in_item;
    dtl_item_t             q_out_item;

    logic                  div_start;
    logic                  div_done;
    logic [2*WORD_W-1:0]   div_num;
    logic [WORD_W:0]       div_den;
    logic [WORD_W-1:0]     div_quo;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[4:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_dt_reg     <= ONE_FIXED;
            spacing_x_reg   <= ONE_FIXED;
            spacing_y_reg   <= ONE_FIXED;
            spacing_z_reg   <= ONE_FIXED;
            axis_enable_reg <= '0;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_STEP_DT:     step_dt_reg     <= pwdata;
                REG_SPACING_X:   spacing_x_reg   <= pwdata;
                REG_SPACING_Y:   spacing_y_reg   <= pwdata;
                REG_SPACING_Z:   spacing_z_reg   <= pwdata;
                REG_AXIS_ENABLE: axis_enable_reg <= pwdata[AXIS_SLOTS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_STEP_DT:     prdata = step_dt_reg;
            REG_SPACING_X:   prdata = spacing_x_reg;
            REG_SPACING_Y:   prdata = spacing_y_reg;
            REG_SPACING_Z:   prdata = spacing_z_reg;
            REG_AXIS_ENABLE: prdata = {{(WORD_W-AXIS_SLOTS){1'b0}}, axis_enable_reg};
            default:         prdata = '0;
        endcase
    end

    assign cfg.step_dt    = step_dt_reg;
    assign cfg.spacing[0] = spacing_x_reg;
    assign cfg.spacing[1] = spacing_y_reg;
    assign cfg.spacing[2] = spacing_z_reg;

    dtl_front u_front (
        .axis_enable (axis_enable_reg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (q_in_item)
    );

    dtl_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_item  (q_out_item)
    );

    dtl_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    dtl_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_item    (q_out_item),
        .q_pop     (q_pop),
        .div_start (div_start),
        .div_num   (div_num),
        .div_den   (div_den),
        .div_done  (div_done),
        .div_quo   (div_quo),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_start_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |=> !div_start)
        else $error("divider start held for more than one cycle");

    a_done_not_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> !div_start)
        else $error("divider restarted while reporting a result");

endmodule

// File: tb/diffusion_timestep_limit_tb.sv
// Self-checking testbench for diffusion_timestep_limit: drives grid points on the
// stream input, programs registers over APB and checks every min_step result.
// Depends on dtl_pkg and the diffusion_timestep_limit RTL.
`timescale 1ns / 1ps

module diffusion_timestep_limit_tb;
    import dtl_pkg::*;

    localparam int DRAIN_CYCLES   = 400;   // up to three points, all axes checked, in flight
    localparam int LONG_HOLD      = 400;
    localparam int QUIET_LIMIT    = 4000;
    localparam int RAND_PHASES    = 8;
    localparam int RAND_ITEMS     = 1000;
    localparam int MAX_PRINTED    = 100;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata  = '0;    // coef_x [31:0], coef_y [63:32], coef_z [95:64]
    logic        s_tuser  = 1'b0;  // in_domain
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // min_step
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // local copy of the block's registers and list state
    logic [31:0] model_step_dt     = ONE_FIXED;
    logic [31:0] model_spacing [3] = '{ONE_FIXED, ONE_FIXED, ONE_FIXED};
    logic [2:0]  model_axis_en     = 3'b000;
    logic [31:0] model_run_min     = 32'hFFFF_FFFF;
    logic        list_fresh        = 1'b1;

    logic [31:0] pending_min_steps [$];
    logic [31:0] want_min_step;

    int mismatch_count  = 0;
    int points_sent     = 0;
    int results_checked = 0;
    int reg_writes      = 0;
    int quiet_cycles    = 0;
    int sink_hold_left  = 0;
    int sink_gap_left   = 0;
    bit src_idle_on     = 1'b1;
    bit sink_idle_on    = 1'b1;

    diffusion_timestep_limit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 aclk = ~aclk;

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTED) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    // floor(h*h / (2*d)), saturated to 32 bits; d is nonzero here
    function automatic logic [31:0] axis_step_limit(input logic [31:0] h, input logic [31:0] d);
        logic [63:0] sq;
        logic [63:0] den;
        logic [63:0] q;
        sq  = {32'd0, h} * {32'd0, h};
        den = {31'd0, d, 1'b0};
        q   = sq / den;
        return (q > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    task automatic predict_min_step(input logic in_dom, input logic [31:0] cx,
                                    input logic [31:0] cy, input logic [31:0] cz,
                                    input logic is_last);
        logic [31:0] coef [3];
        logic [31:0] cur;
        logic [31:0] lim;
        coef[0] = cx;
        coef[1] = cy;
        coef[2] = cz;
        cur = list_fresh ? model_step_dt : model_run_min;
        if (in_dom) begin
            for (int a = 0; a < AXES; a++) begin
                if (model_axis_en[a] && coef[a] != 32'd0) begin
                    lim = axis_step_limit(model_spacing[a], coef[a]);
                    if (lim < cur) cur = lim;
                end
            end
        end
        if (is_last) begin
            pending_min_steps.push_back(cur);
            model_run_min = 32'hFFFF_FFFF;
            list_fresh    = 1'b1;
        end else begin
            model_run_min = cur;
            list_fresh    = 1'b0;
        end
        points_sent++;
    endtask

    // offer one point, hold it until taken, then predict its effect
    task automatic send_point(input logic in_dom, input logic [31:0] cx,
                              input logic [31:0] cy, input logic [31:0] cz,
                              input logic is_last);
        int gap;
        if (src_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {cz, cy, cx};
        s_tuser  <= in_dom;
        s_tlast  <= is_last;
        do @(posedge aclk); while (s_tready !== 1'b1);
        predict_min_step(in_dom, cx, cy, cz, is_last);
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        while (pending_min_steps.size() != 0) @(posedge aclk);
    endtask

    // registers change only once the back end has nothing left to do
    task automatic wait_idle();
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_STEP_DT:     model_step_dt    = val;
            REG_SPACING_X:   model_spacing[0] = val;
            REG_SPACING_Y:   model_spacing[1] = val;
            REG_SPACING_Z:   model_spacing[2] = val;
            REG_AXIS_ENABLE: model_axis_en    = val[2:0];
            default: ;
        endcase
        reg_writes++;
        @(posedge aclk);
    endtask

    task automatic load_config(input logic [31:0] dt, input logic [31:0] hx,
                               input logic [31:0] hy, input logic [31:0] hz,
                               input logic [2:0] en);
        write_reg(REG_STEP_DT, dt);
        write_reg(REG_SPACING_X, hx);
        write_reg(REG_SPACING_Y, hy);
        write_reg(REG_SPACING_Z, hz);
        write_reg(REG_AXIS_ENABLE, {29'd0, en});
    endtask

    function automatic logic [31:0] pick_coef();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'($urandom_range(1, 255));
            3:       return 32'd1 << $urandom_range(0, 31);
            4:       return ONE_FIXED;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return ONE_FIXED;
            3, 4:    return $urandom() >> $urandom_range(0, 24);
            default: return $urandom();
        endcase
    endfunction

    task automatic test_reset_defaults();
        // no axis enabled out of reset: the list yields step_dt = 1.0
        send_point(1'b1, ONE_FIXED, 32'h0002_0000, 32'd1, 1'b0);
        send_point(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    endtask

    task automatic test_special_cases();
        wait_idle();
        load_config(ONE_FIXED, ONE_FIXED, ONE_FIXED, ONE_FIXED, 3'b111);
        send_point(1'b0, 32'd1, 32'd1, 32'd1, 1'b1);                     // outside domain
        send_point(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_point(1'b1, 32'd0, 32'd0, 32'd0, 1'b1);                     // all axes skipped
        send_point(1'b1, 32'd1, 32'd0, 32'd0, 1'b1);                     // limit above step
        wait_idle();
        load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, ONE_FIXED, 3'b111);
        send_point(1'b1, 32'd1, 32'd0, 32'd0, 1'b1);                     // saturated quotient
        send_point(1'b1, 32'd0, 32'd5, 32'd0, 1'b1);                     // zero spacing
        send_point(1'b1, 32'd0, 32'd0, 32'h0000_8000, 1'b1);
    endtask

    task automatic test_axis_select();
        logic [2:0] sel [4];
        sel = '{3'b001, 3'b010, 3'b100, 3'b000};
        wait_idle();
        load_config(32'hFFFF_FFFF, ONE_FIXED, ONE_FIXED, ONE_FIXED, 3'b000);
        for (int i = 0; i < 4; i++) begin
            wait_idle();
            write_reg(REG_AXIS_ENABLE, {29'd0, sel[i]});
            send_point(1'b1, 32'h0002_0000, 32'h0004_0000, 32'h0008_0000, 1'b0);
            send_point(1'b1, 32'h0008_0000, 32'h0002_0000, 32'h0004_0000, 1'b1);
        end
    endtask

    task automatic test_midlist_step();
        wait_idle();
        load_config(ONE_FIXED, ONE_FIXED, ONE_FIXED, ONE_FIXED, 3'b000);
        send_point(1'b1, ONE_FIXED, ONE_FIXED, ONE_FIXED, 1'b0);
        wait_idle();
        // new step only applies from the next list on
        write_reg(REG_STEP_DT, 32'h0000_4000);
        send_point(1'b1, ONE_FIXED, ONE_FIXED, ONE_FIXED, 1'b1);
        send_point(1'b0, ONE_FIXED, ONE_FIXED, ONE_FIXED, 1'b1);
    endtask

    task automatic test_register_index_range();
        wait_idle();
        for (int i = REG_AXIS_ENABLE + 1; i < 8; i++) begin
            write_reg(3'(i), 32'd0);
        end
        send_point(1'b1, ONE_FIXED, 32'd3, 32'd7, 1'b1);
    endtask

    task automatic test_backpressure();
        wait_idle();
        load_config(pick_word(), pick_word(), pick_word(), pick_word(), 3'b111);
        src_idle_on    = 1'b0;
        sink_hold_left = LONG_HOLD;
        for (int i = 0; i < 30; i++) begin
            send_point(1'b1, pick_coef(), pick_coef(), pick_coef(), $urandom_range(0, 3) != 0);
        end
        src_idle_on = 1'b1;
    endtask

    task automatic test_random_lists();
        int n;
        int len;
        for (int p = 0; p < RAND_PHASES; p++) begin
            wait_idle();
            case (p)
                0:       load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                     32'hFFFF_FFFF, 3'b111);
                1:       load_config(32'd0, pick_word(), pick_word(), pick_word(), 3'b111);
                2:       load_config(ONE_FIXED, ONE_FIXED, ONE_FIXED, ONE_FIXED, 3'b000);
                default: load_config(pick_word(), pick_word(), pick_word(), pick_word(),
                                     3'($urandom_range(0, 7)));
            endcase
            // last phase runs at full rate on both sides
            src_idle_on  = (p != RAND_PHASES - 1) && (p % 3 != 1);
            sink_idle_on = (p != RAND_PHASES - 1) && (p % 3 != 2);
            n = 0;
            while (n < RAND_ITEMS / RAND_PHASES) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 4);
                for (int k = 0; k < len; k++) begin
                    send_point($urandom_range(0, 6) != 0, pick_coef(), pick_coef(), pick_coef(),
                               k == len - 1);
                    n++;
                end
                if (src_idle_on && $urandom_range(0, 15) == 0) hold_until_drained();
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_special_cases();
        test_axis_select();
        test_midlist_step();
        test_register_index_range();
        test_backpressure();
        test_random_lists();
        wait_idle();
        $display("Covered %0d grid points, %0d min_step results and %0d register writes,",
                 points_sent, results_checked, reg_writes);
        $display("with saturation, zero spacing, axis masking and a long output stall.");
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // result side: random stall bursts plus an occasional long hold
    always @(posedge aclk) begin
        if (sink_hold_left > 0) begin
            m_tready <= 1'b0;
            sink_hold_left--;
        end else if (sink_gap_left > 0) begin
            m_tready <= 1'b0;
            sink_gap_left--;
        end else if (sink_idle_on && $urandom_range(0, 9) == 0) begin
            m_tready <= 1'b0;
            sink_gap_left = $urandom_range(1, 18) - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (pending_min_steps.size() == 0) begin
                report_mismatch($sformatf("min_step %h with no list pending", m_tdata));
            end else begin
                want_min_step = pending_min_steps.pop_front();
                if (m_tdata !== want_min_step) begin
                    report_mismatch($sformatf("min_step got %h expected %h",
                                              m_tdata, want_min_step));
                end
                results_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no request moved for %0d cycles", QUIET_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule
